[hdl/amb_pkg.sv]
`timescale 1ns / 1ps
package amb_pkg;

  typedef enum logic [1:0] {
    ACT_ROTATE    = 2'd0,
    ACT_SCALE     = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_IDENTITY  = 2'd3
  } action_e;

  // one full matrix, [row][col], Q(FRAC_BITS) entries
  typedef logic [3:0][3:0][31:0] mat_t;
  // rotation block of the matrix, [row][col]
  typedef logic [2:0][2:0][31:0] rot_t;

  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES      = 24;

  // angle reduction works on a widened Q30 word
  localparam int ZW        = 57;
  localparam int CW        = 34;
  localparam int PW        = 70;
  localparam int RED_STEPS = 23;
  localparam int MAT_LAT   = 3;

  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 57'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_PI      = 57'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 57'sd1686629713;
  localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

  function automatic int cordic_n(input int stages);
    return (stages > ATAN_ENTRIES) ? ATAN_ENTRIES : stages;
  endfunction

  // register stages of one sine/cosine lane
  function automatic int lane_lat(input int stages);
    return 2 + RED_STEPS + cordic_n(stages);
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    case (i)
      0:  return 34'sd843314856;
      1:  return 34'sd497837829;
      2:  return 34'sd263043836;
      3:  return 34'sd133525158;
      4:  return 34'sd67021686;
      5:  return 34'sd33543515;
      6:  return 34'sd16775850;
      7:  return 34'sd8388437;
      8:  return 34'sd4194282;
      9:  return 34'sd2097149;
      10: return 34'sd1048575;
      11: return 34'sd524287;
      12: return 34'sd262143;
      13: return 34'sd131071;
      14: return 34'sd65535;
      15: return 34'sd32767;
      16: return 34'sd16383;
      17: return 34'sd8191;
      18: return 34'sd4095;
      19: return 34'sd2047;
      20: return 34'sd1023;
      21: return 34'sd511;
      22: return 34'sd255;
      23: return 34'sd127;
      default: return '0;
    endcase
  endfunction

  // round half up by sh bits, then saturate to 32 bits
  function automatic logic [31:0] rnd_sat(input logic signed [PW-1:0] v, input int sh);
    logic signed [PW-1:0] t;
    t = (v + (70'sd1 <<< (sh - 1))) >>> sh;
    if (t > 70'sd2147483647) return 32'h7fff_ffff;
    else if (t < -70'sd2147483648) return 32'h8000_0000;
    else return t[31:0];
  endfunction

endpackage

[hdl/amb_sincos.sv]
`timescale 1ns / 1ps
module amb_sincos #(
  parameter int FRAC_BITS     = amb_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STAGES = amb_pkg::DEF_CORDIC_STAGES
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [31:0]                    angle_i,
  output logic signed [amb_pkg::CW-1:0]  sin_o,
  output logic signed [amb_pkg::CW-1:0]  cos_o
);

  localparam int ZW = amb_pkg::ZW;
  localparam int CW = amb_pkg::CW;
  localparam int RS = amb_pkg::RED_STEPS;
  localparam int NC = amb_pkg::cordic_n(CORDIC_STAGES);
  localparam int SH = 30 - FRAC_BITS;

  logic signed [ZW-1:0] red_q [0:RS];
  logic signed [CW-1:0] x_q [0:NC];
  logic signed [CW-1:0] y_q [0:NC];
  logic signed [CW-1:0] z_q [0:NC];
  logic                 flip_q [0:NC];
  logic signed [ZW-1:0] wrap_d, fold_d;
  logic                 flip_d;

  // scale to Q30 and bias positive; floor modulo is unchanged by the bias
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q[0] <= ($signed({{(ZW-32){angle_i[31]}}, angle_i}) <<< SH)
                  + (amb_pkg::Q30_TWO_PI <<< (RS - 2));
    end
  end

  // restoring reduction, one multiple of 2pi per stage
  for (genvar k = 1; k <= RS; k++) begin : g_red
    localparam logic signed [ZW-1:0] BOUND = amb_pkg::Q30_TWO_PI <<< (RS - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        red_q[k] <= (red_q[k-1] >= BOUND) ? red_q[k-1] - BOUND : red_q[k-1];
      end
    end
  end

  // fold into [-pi/2, pi/2]
  always_comb begin
    wrap_d = (red_q[RS] >= amb_pkg::Q30_PI) ? red_q[RS] - amb_pkg::Q30_TWO_PI : red_q[RS];
    flip_d = 1'b0;
    fold_d = wrap_d;
    if (wrap_d > amb_pkg::Q30_HALF_PI) begin
      fold_d = wrap_d - amb_pkg::Q30_PI;
      flip_d = 1'b1;
    end else if (wrap_d < -amb_pkg::Q30_HALF_PI) begin
      fold_d = wrap_d + amb_pkg::Q30_PI;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= amb_pkg::Q30_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= fold_d[CW-1:0];
      flip_q[0] <= flip_d;
    end
  end

  // CORDIC rotation stages
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN = amb_pkg::atan_q30(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign sin_o = flip_q[NC] ? -y_q[NC] : y_q[NC];
  assign cos_o = flip_q[NC] ? -x_q[NC] : x_q[NC];

endmodule

[hdl/amb_matrix.sv]
`timescale 1ns / 1ps
module amb_matrix #(
  parameter int FRAC_BITS = amb_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [amb_pkg::CW-1:0] sx_i,
  input  logic signed [amb_pkg::CW-1:0] cx_i,
  input  logic signed [amb_pkg::CW-1:0] sy_i,
  input  logic signed [amb_pkg::CW-1:0] cy_i,
  input  logic signed [amb_pkg::CW-1:0] sz_i,
  input  logic signed [amb_pkg::CW-1:0] cz_i,
  output amb_pkg::rot_t                 rot_o
);

  localparam int CW = amb_pkg::CW;
  localparam int PW = amb_pkg::PW;
  localparam int QS = 60 - FRAC_BITS;

  logic signed [2*CW-1:0] cycz_a, cysz_a, sxcy_a, cxcy_a, cxsz_a, cxcz_a, sxsz_a, sxcz_a;
  logic signed [2*CW-1:0] cycz_b, cysz_b, sxcy_b, cxcy_b, cxsz_b, cxcz_b, sxsz_b, sxcz_b;
  logic signed [2*CW-1:0] sxsycz_b, sxsysz_b, cxsycz_b, cxsysz_b;
  logic signed [2*CW-1:0] sxsy_p, cxsy_p;
  logic signed [CW-1:0]   sxsy_a, cxsy_a, sy_a, sz_a, cz_a, sy_b;
  amb_pkg::rot_t          rot_q;

  assign sxsy_p = (sx_i * sy_i + (68'sd1 <<< 29)) >>> 30;
  assign cxsy_p = (cx_i * sy_i + (68'sd1 <<< 29)) >>> 30;

  // stage A: two-factor products and the rounded inner products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycz_a <= cy_i * cz_i;
      cysz_a <= cy_i * sz_i;
      sxcy_a <= sx_i * cy_i;
      cxcy_a <= cx_i * cy_i;
      cxsz_a <= cx_i * sz_i;
      cxcz_a <= cx_i * cz_i;
      sxsz_a <= sx_i * sz_i;
      sxcz_a <= sx_i * cz_i;
      sxsy_a <= sxsy_p[CW-1:0];
      cxsy_a <= cxsy_p[CW-1:0];
      sy_a   <= sy_i;
      sz_a   <= sz_i;
      cz_a   <= cz_i;
    end
  end

  // stage B: three-factor products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sxsycz_b <= sxsy_a * cz_a;
      sxsysz_b <= sxsy_a * sz_a;
      cxsycz_b <= cxsy_a * cz_a;
      cxsysz_b <= cxsy_a * sz_a;
      cycz_b   <= cycz_a;
      cysz_b   <= cysz_a;
      sxcy_b   <= sxcy_a;
      cxcy_b   <= cxcy_a;
      cxsz_b   <= cxsz_a;
      cxcz_b   <= cxcz_a;
      sxsz_b   <= sxsz_a;
      sxcz_b   <= sxcz_a;
      sy_b     <= sy_a;
    end
  end

  // stage C: sums, rounding and saturation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q[0][0] <= amb_pkg::rnd_sat(PW'(cycz_b), QS);
      rot_q[0][1] <= amb_pkg::rnd_sat(PW'(cysz_b), QS);
      rot_q[0][2] <= amb_pkg::rnd_sat(-PW'(sy_b), 30 - FRAC_BITS);
      rot_q[1][0] <= amb_pkg::rnd_sat(PW'(sxsycz_b) - PW'(cxsz_b), QS);
      rot_q[1][1] <= amb_pkg::rnd_sat(PW'(sxsysz_b) + PW'(cxcz_b), QS);
      rot_q[1][2] <= amb_pkg::rnd_sat(PW'(sxcy_b), QS);
      rot_q[2][0] <= amb_pkg::rnd_sat(PW'(cxsycz_b) + PW'(sxsz_b), QS);
      rot_q[2][1] <= amb_pkg::rnd_sat(PW'(cxsysz_b) - PW'(sxcz_b), QS);
      rot_q[2][2] <= amb_pkg::rnd_sat(PW'(cxcy_b), QS);
    end
  end

  assign rot_o = rot_q;

endmodule

[hdl/amb_row_queue.sv]
`timescale 1ns / 1ps
module amb_row_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  amb_pkg::mat_t push_data_i,
  output logic          full_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,  // row_index[1:0], entry_col0..3 at [33:2]..[129:98]
  output logic          m_axis_tlast   // last_row
);

  amb_pkg::mat_t mat_q [0:1];
  logic [1:0]    cnt_q, cnt_d;
  logic          wptr_q, rptr_q;
  logic [1:0]    row_q;
  logic          take, pop;

  assign take = m_axis_tvalid && m_axis_tready;
  assign pop  = take && (row_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mat_q[wptr_q] <= push_data_i;
    end
  end

  // pointers, fill count and row counter
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      row_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      if (take) row_q <= row_q + 2'd1;
    end
  end

  assign full_o        = (cnt_q == 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = (row_q == 2'd3);
  assign m_axis_tdata  = {6'd0, mat_q[rptr_q][row_q][3], mat_q[rptr_q][row_q][2],
                          mat_q[rptr_q][row_q][1], mat_q[rptr_q][row_q][0], row_q};

endmodule

[hdl/affine_transform_matrix_builder.sv]
`timescale 1ns / 1ps
// 4x4 homogeneous transform builder.
// Input stream: tuser carries the action (0 rotate, 1 scale, 2 translate,
// 3 gives the identity), tdata the X, Y and Z values in signed Q16.16.
// For rotate the values are angles in radians; sines and cosines come from
// three pipelined CORDIC lanes; R = (Rz*Ry*Rx)^T is formed in a three-stage
// multiply pipeline. Scale and translate pass the values into the matrix.
// Output stream: four requests per item, one matrix row each, in row order;
// tlast marks row 3. tdata carries the row index and the four entries.
// Row 0 becomes valid once the accepted request has passed the angle
// reduction, CORDIC and matrix stages and entered the queue. A new item may
// enter every cycle the pipeline moves; sustained throughput is set by the
// output port, which emits one row per cycle while the receiver is ready.
// A two-matrix queue sits between the compute pipeline and the row
// sender. When the receiver stalls, the queue fills and the pipeline
// freezes in place; s_axis_tready drops only while the last pipeline stage
// holds an item and the queue is full. Reset empties the queue and marks
// every pipeline stage invalid; no state is kept between items.
module affine_transform_matrix_builder #(
  parameter int FRAC_BITS     = amb_pkg::DEF_FRAC_BITS,
  parameter int CORDIC_STAGES = amb_pkg::DEF_CORDIC_STAGES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // first_value, second_value, third_value
  input  logic [1:0]   s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // row_index, entry_col0..entry_col3, zero pad
  output logic         m_axis_tlast    // last_row
);

  localparam int LAT = amb_pkg::lane_lat(CORDIC_STAGES) + amb_pkg::MAT_LAT;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic                          en;
  logic                          full;
  logic [LAT-1:0]                vld_q;
  logic [1:0]                    act_q [0:LAT-1];
  logic [95:0]                   val_q [0:LAT-1];
  logic signed [amb_pkg::CW-1:0] sx, cx, sy, cy, sz, cz;
  amb_pkg::rot_t                 rot;
  amb_pkg::mat_t                 mat;

  // whole pipeline advances unless its finished item cannot enter the queue
  assign en            = !(vld_q[LAT-1] && full);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // side data rides alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_q[0] <= s_axis_tuser;
      val_q[0] <= s_axis_tdata;
      for (int i = 1; i < LAT; i++) begin
        act_q[i] <= act_q[i-1];
        val_q[i] <= val_q[i-1];
      end
    end
  end

  amb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_x (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[31:0]), .sin_o(sx), .cos_o(cx)
  );
  amb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_y (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[63:32]), .sin_o(sy), .cos_o(cy)
  );
  amb_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_z (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[95:64]), .sin_o(sz), .cos_o(cz)
  );

  amb_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i(clk_i), .en_i(en),
    .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy), .sz_i(sz), .cz_i(cz),
    .rot_o(rot)
  );

  // assemble the full matrix by action
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = (r == c) ? ONE : 32'd0;
      end
    end
    case (amb_pkg::action_e'(act_q[LAT-1]))
      amb_pkg::ACT_ROTATE: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            mat[r][c] = rot[r][c];
          end
        end
      end
      amb_pkg::ACT_SCALE: begin
        mat[0][0] = val_q[LAT-1][31:0];
        mat[1][1] = val_q[LAT-1][63:32];
        mat[2][2] = val_q[LAT-1][95:64];
      end
      amb_pkg::ACT_TRANSLATE: begin
        mat[0][3] = val_q[LAT-1][31:0];
        mat[1][3] = val_q[LAT-1][63:32];
        mat[2][3] = val_q[LAT-1][95:64];
      end
      default: begin
      end
    endcase
  end

  amb_row_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(en && vld_q[LAT-1]), .push_data_i(mat), .full_o(full),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[LAT-1]) |-> !full) else $error("push into full queue");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (vld_q[LAT-1] && full)) else $error("stall without cause");
  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> m_axis_tvalid) else $error("full queue shows no row");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved while stalled");

endmodule
